[rtl/core/ppm_pkg.sv]
// Shared types, byte codes and helper functions for the P6 stream parser.
// Used by every module of the parser; depends on nothing else.
package ppm_pkg;

    // Header number limits
    localparam int unsigned MAX_DIGITS = 4;
    localparam int unsigned DCNT_W     = $clog2(MAX_DIGITS + 1);
    localparam int unsigned DIM_W      = 14;
    localparam int unsigned PIXCNT_W   = 29;
    localparam int unsigned STATUS_W   = 3;
    localparam int unsigned OUT_DATA_W = 40;
    localparam int unsigned OUT_USER_W = 2;

    // Byte codes met in the header
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_SIX   = 8'h36;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    localparam logic [DIM_W-1:0] MAXVAL_OK = DIM_W'(255);

    // Report status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_VERSION   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_WIDTH     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_MAXVAL_NE = 3'd5;
    localparam logic [STATUS_W-1:0] ST_SIZE      = 3'd6;
    localparam logic [STATUS_W-1:0] ST_TRUNC     = 3'd7;

    // Header field being read
    localparam logic [1:0] FLD_WIDTH  = 2'd0;
    localparam logic [1:0] FLD_HEIGHT = 2'd1;
    localparam logic [1:0] FLD_MAXVAL = 2'd2;

    // Parse phase, one-hot
    typedef enum logic [6:0] {
        PH_P     = 7'b000_0001,
        PH_SIX   = 7'b000_0010,
        PH_CMT0  = 7'b000_0100,
        PH_FIELD = 7'b000_1000,
        PH_CMT1  = 7'b001_0000,
        PH_PIX   = 7'b010_0000,
        PH_ERR   = 7'b100_0000
    } t_phase;

    // One input word as held in the input register
    typedef struct packed {
        logic [7:0] file_byte;
        logic       end_of_file;
    } t_in_word;

    // One result word
    typedef struct packed {
        logic                pixel_valid;
        logic [7:0]          pixel_byte;
        logic                report_valid;
        logic [STATUS_W-1:0] status;
        logic [DIM_W-1:0]    image_width;
        logic [DIM_W-1:0]    image_height;
    } t_result;

    function automatic logic is_space(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);
    endfunction

    function automatic logic is_eol(input logic [7:0] b);
        return (b == CH_CR) || (b == CH_LF);
    endfunction

    // Error status for a bad token in the current field (width, height, maxval)
    function automatic logic [STATUS_W-1:0] field_status(input logic [1:0] fld);
        logic [1:0] f;
        f = (fld > FLD_MAXVAL) ? FLD_MAXVAL : fld;
        return ST_WIDTH + {1'b0, f};
    endfunction

endpackage

[rtl/core/ppm_in_stage.sv]
// Input register of the P6 parser: holds one accepted byte until the parser takes it.
// Depends on ppm_pkg.
module ppm_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  ppm_pkg::t_in_word i_word,
    input  logic              i_step,
    output logic              o_valid,
    output ppm_pkg::t_in_word o_word
);
    import ppm_pkg::*;

    logic     r_valid;
    t_in_word r_word;

    // A new word may enter when the register is empty or is being consumed.
    assign o_ready = !r_valid || i_step;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    // Occupancy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_step) begin
            r_valid <= 1'b0;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_word <= i_word;
        end
    end

endmodule

[rtl/core/ppm_hdr_parser.sv]
// Header parser state and per-word update of the P6 parser.
// Produces the result word for each stepped byte; depends on ppm_pkg.
module ppm_hdr_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  ppm_pkg::t_in_word i_word,
    output logic              o_res_valid,
    output ppm_pkg::t_result  o_res
);
    import ppm_pkg::*;

    t_phase              r_phase,  n_phase;
    logic [1:0]          r_field,  n_field;
    logic [DCNT_W-1:0]   r_dcnt,   n_dcnt;
    logic [DIM_W-1:0]    r_number, n_number;
    logic [DIM_W-1:0]    r_width,  n_width;
    logic [DIM_W-1:0]    r_height, n_height;
    logic [PIXCNT_W-1:0] r_remain, n_remain;
    logic [STATUS_W-1:0] r_error,  n_error;

    logic [7:0]          b;
    logic                digit_byte;
    logic [3:0]          digit_val;
    logic [DIM_W+3:0]    num_x10;
    logic [2*DIM_W-1:0]  area;
    logic [2*DIM_W+1:0]  area_x3;
    logic [STATUS_W-1:0] rep_status;

    assign b          = i_word.file_byte;
    assign digit_byte = (b >= CH_ZERO) && (b <= CH_NINE);

    // For an ASCII digit the low nibble is its value.
    assign digit_val = b[3:0];

    // Decimal accumulate by shift and add: 8x + 2x
    assign num_x10 = {1'b0, r_number, 3'b0} + {3'b0, r_number, 1'b0};

    // Pixel byte count: width * height * 3
    assign area    = r_width * r_height;
    assign area_x3 = {2'b0, area} + {1'b0, area, 1'b0};

    // Next-state and result logic for one byte
    always_comb begin
        n_phase    = r_phase;
        n_field    = r_field;
        n_dcnt     = r_dcnt;
        n_number   = r_number;
        n_width    = r_width;
        n_height   = r_height;
        n_remain   = r_remain;
        n_error    = r_error;
        rep_status = ST_OK;
        o_res      = '0;

        unique case (r_phase)
            PH_P: begin
                if (b == CH_HASH) begin
                    n_phase = PH_CMT0;
                end else if (is_space(b)) begin
                    n_phase = PH_P;
                end else if (b == CH_P) begin
                    n_phase = PH_SIX;
                end else begin
                    n_phase = PH_ERR;
                    n_error = ST_VERSION;
                end
            end
            PH_SIX: begin
                if (b == CH_SIX) begin
                    n_phase  = PH_FIELD;
                    n_field  = FLD_WIDTH;
                    n_dcnt   = '0;
                    n_number = '0;
                end else begin
                    n_phase = PH_ERR;
                    n_error = ST_VERSION;
                end
            end
            PH_CMT0: begin
                if (is_eol(b)) begin
                    n_phase = PH_P;
                end
            end
            PH_CMT1: begin
                if (is_eol(b)) begin
                    n_phase = PH_FIELD;
                end
            end
            PH_FIELD: begin
                if (digit_byte) begin
                    if (r_dcnt >= DCNT_W'(MAX_DIGITS)) begin
                        n_phase = PH_ERR;
                        n_error = field_status(r_field);
                    end else begin
                        n_number = num_x10[DIM_W-1:0] + {{(DIM_W-4){1'b0}}, digit_val};
                        n_dcnt   = r_dcnt + DCNT_W'(1);
                    end
                end else if (is_space(b)) begin
                    // Whitespace ends a number that has digits
                    if (r_dcnt != '0) begin
                        n_number = '0;
                        n_dcnt   = '0;
                        priority if (r_field == FLD_WIDTH) begin
                            n_width = r_number;
                            n_field = FLD_HEIGHT;
                        end else if (r_field == FLD_HEIGHT) begin
                            n_height = r_number;
                            n_field  = FLD_MAXVAL;
                        end else if (r_number != MAXVAL_OK) begin
                            n_phase = PH_ERR;
                            n_error = ST_MAXVAL_NE;
                        end else begin
                            n_remain = area_x3[PIXCNT_W-1:0];
                            n_phase  = PH_PIX;
                        end
                    end
                end else if ((b == CH_HASH) && (r_dcnt == '0)) begin
                    n_phase = PH_CMT1;
                end else begin
                    n_phase = PH_ERR;
                    n_error = field_status(r_field);
                end
            end
            PH_PIX: begin
                if (r_remain != '0) begin
                    o_res.pixel_valid = 1'b1;
                    o_res.pixel_byte  = b;
                    n_remain          = r_remain - PIXCNT_W'(1);
                end else begin
                    n_phase = PH_ERR;
                    n_error = ST_SIZE;
                end
            end
            PH_ERR: begin
                n_phase = PH_ERR;
            end
            default: begin
                n_phase = PH_ERR;
                n_error = ST_TRUNC;
            end
        endcase

        // Final byte: report from the updated state, then start over
        if (i_word.end_of_file) begin
            priority if (n_phase == PH_ERR) begin
                rep_status = n_error;
            end else if (n_phase == PH_PIX) begin
                rep_status = (n_remain == '0) ? ST_OK : ST_SIZE;
            end else if ((n_phase == PH_FIELD) && (n_dcnt != '0)) begin
                rep_status = field_status(n_field);
            end else begin
                rep_status = ST_TRUNC;
            end
            o_res.report_valid = 1'b1;
            o_res.status       = rep_status;
            o_res.image_width  = n_width;
            o_res.image_height = n_height;

            n_phase  = PH_P;
            n_field  = FLD_WIDTH;
            n_dcnt   = '0;
            n_number = '0;
            n_width  = '0;
            n_height = '0;
            n_remain = '0;
            n_error  = ST_OK;
        end
    end

    assign o_res_valid = o_res.pixel_valid || o_res.report_valid;

    // Parser state registers, updated only when a byte is stepped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_P;
            r_field  <= FLD_WIDTH;
            r_dcnt   <= '0;
            r_number <= '0;
            r_width  <= '0;
            r_height <= '0;
            r_remain <= '0;
            r_error  <= ST_OK;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_field  <= n_field;
            r_dcnt   <= n_dcnt;
            r_number <= n_number;
            r_width  <= n_width;
            r_height <= n_height;
            r_remain <= n_remain;
            r_error  <= n_error;
        end
    end

endmodule

[rtl/core/ppm_out_reg.sv]
// Output register of the P6 parser: holds one result word until the sink takes it.
// Depends on ppm_pkg.
module ppm_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  ppm_pkg::t_result i_res,
    input  logic             i_ready,
    output logic             o_valid,
    output ppm_pkg::t_result o_res
);
    import ppm_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_valid = r_valid;
    assign o_res   = r_res;

    // Occupancy flag: a load wins over a take in the same cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

[rtl/core/ppm_p6_stream_parser_core.sv]
// Top level of the P6 stream parser: input register, header parser, output register.
// Depends on ppm_pkg, ppm_in_stage, ppm_hdr_parser and ppm_out_reg.
//
//  Channel   Dir  tdata (low bit up)                          tuser / tlast
//  s_axis    in   file_byte[7:0]                              tlast = end_of_file
//  m_axis    out  pixel_byte, status, image_width,            tuser = pixel_valid,
//                 image_height, zero fill to 40 bits                  report_valid
//
// One word is accepted per cycle unless m_axis stalls; a result passes both registers.
// A word that gives no result (header bytes) only updates the parser state.
// The parser steps whenever the output register is empty or being emptied, so a
// stall on m_axis holds one word in each register and then lowers s_axis tready.
// Reset is synchronous and active low; it returns the parser to the start of a file.
module ppm_p6_stream_parser_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [7:0]                     i_s_axis_tdata,  // file_byte[7:0]
    input  logic                           i_s_axis_tlast,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // pixel_byte[7:0], status[10:8], image_width[24:11], image_height[38:25]
    output logic [ppm_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    // pixel_valid[0], report_valid[1]
    output logic [ppm_pkg::OUT_USER_W-1:0] o_m_axis_tuser
);
    import ppm_pkg::*;

    t_in_word in_word, held_word;
    logic     held_valid;
    logic     step;
    logic     res_valid;
    t_result  res, out_res;

    assign in_word.file_byte   = i_s_axis_tdata;
    assign in_word.end_of_file = i_s_axis_tlast;

    // The held byte moves on when the output register can take a result
    assign step = held_valid && (!o_m_axis_tvalid || i_m_axis_tready);

    ppm_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_word  (in_word),
        .i_step  (step),
        .o_valid (held_valid),
        .o_word  (held_word)
    );

    ppm_hdr_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_word      (held_word),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    ppm_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (step && res_valid),
        .i_res   (res),
        .i_ready (i_m_axis_tready),
        .o_valid (o_m_axis_tvalid),
        .o_res   (out_res)
    );

    // Pack the result word onto the stream
    assign o_m_axis_tdata = {1'b0, out_res.image_height, out_res.image_width,
                             out_res.status, out_res.pixel_byte};
    assign o_m_axis_tuser = {out_res.report_valid, out_res.pixel_valid};

    // A word on the output always carries a pixel or a report
    a_out_has_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (out_res.pixel_valid || out_res.report_valid))
        else $error("output word carries neither pixel nor report");

    // Report fields are zero on a pixel-only word
    a_no_report_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !out_res.report_valid) |->
        (out_res.status == ST_OK && out_res.image_width == '0 && out_res.image_height == '0))
        else $error("report fields set on a word without a report");

    // A byte that is not a pixel shows as zero
    a_no_pixel_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !out_res.pixel_valid) |-> (out_res.pixel_byte == '0))
        else $error("pixel byte set on a word without a pixel");

    // The parser never steps a byte while the output register is stalled
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> $stable(out_res))
        else $error("output register overwritten during a stall");

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the P6 stream parser: a clocked driver feeds whole files,
// a clocked monitor checks every output word against an in-bench parser model.
// Depends on ppm_pkg and ppm_p6_stream_parser_core.
module tb;
    import ppm_pkg::*;

    // Clock and reset
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Stream signals driven by the bench
    logic                  src_valid = 1'b0;
    logic [7:0]            src_byte  = 8'h00;
    logic                  src_last  = 1'b0;
    logic                  sink_ready = 1'b0;
    logic                  src_ready;
    logic                  out_valid;
    logic [OUT_DATA_W-1:0] out_data;
    logic [OUT_USER_W-1:0] out_user;

    ppm_p6_stream_parser_core DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (src_valid),
        .o_s_axis_tready (src_ready),
        .i_s_axis_tdata  (src_byte),
        .i_s_axis_tlast  (src_last),
        .o_m_axis_tvalid (out_valid),
        .i_m_axis_tready (sink_ready),
        .o_m_axis_tdata  (out_data),
        .o_m_axis_tuser  (out_user)
    );

    // Stimulus and scoreboard storage
    t_in_word   file_words_q[$];
    t_result    predicted_out_q[$];
    logic [7:0] file_buf[$];

    int total_words  = 1;
    int n_acc        = 0;
    int n_files      = 0;
    int n_pixels     = 0;
    int n_reports    = 0;
    int n_errors     = 0;
    int status_hits[8];
    int hold_left    = 0;
    bit hold_done    = 1'b0;

    // Parser model state
    t_phase              ph;
    logic [1:0]          fld;
    logic [2:0]          ndig;
    logic [DIM_W-1:0]    acc;
    logic [DIM_W-1:0]    wd;
    logic [DIM_W-1:0]    ht;
    logic [PIXCNT_W-1:0] left;
    logic [STATUS_W-1:0] err;

    function automatic bit is_ws(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);
    endfunction

    function automatic bit is_line_end(input logic [7:0] b);
        return (b == CH_CR) || (b == CH_LF);
    endfunction

    // Status for a bad token in whichever header number is being read.
    function automatic logic [STATUS_W-1:0] bad_field_code();
        logic [1:0] f;
        f = (fld > FLD_MAXVAL) ? FLD_MAXVAL : fld;
        return ST_WIDTH + STATUS_W'(f);
    endfunction

    task automatic reset_parser();
        ph   = PH_P;
        fld  = FLD_WIDTH;
        ndig = '0;
        acc  = '0;
        wd   = '0;
        ht   = '0;
        left = '0;
        err  = ST_OK;
    endtask

    task automatic abort_file(input logic [STATUS_W-1:0] code);
        err = code;
        ph  = PH_ERR;
    endtask

    // Advance the model by one accepted byte and queue the word it should produce.
    task automatic parse_byte(input logic [7:0] b, input logic eof);
        t_result r;
        r = '0;
        case (ph)
            PH_P: begin
                if (b == CH_HASH) ph = PH_CMT0;
                else if (is_ws(b)) ph = PH_P;
                else if (b == CH_P) ph = PH_SIX;
                else abort_file(ST_VERSION);
            end
            PH_SIX: begin
                if (b == CH_SIX) begin
                    ph   = PH_FIELD;
                    fld  = FLD_WIDTH;
                    ndig = '0;
                    acc  = '0;
                end else begin
                    abort_file(ST_VERSION);
                end
            end
            PH_CMT0: if (is_line_end(b)) ph = PH_P;
            PH_CMT1: if (is_line_end(b)) ph = PH_FIELD;
            PH_FIELD: begin
                if (b >= CH_ZERO && b <= CH_NINE) begin
                    if (ndig >= MAX_DIGITS) begin
                        abort_file(bad_field_code());
                    end else begin
                        acc  = DIM_W'(acc * 10 + (b - CH_ZERO));
                        ndig = ndig + 1'b1;
                    end
                end else if (is_ws(b)) begin
                    // Whitespace closes a number that has digits.
                    if (ndig != 0) begin
                        ndig = '0;
                        if (fld == FLD_WIDTH) begin
                            wd  = acc;
                            fld = FLD_HEIGHT;
                        end else if (fld == FLD_HEIGHT) begin
                            ht  = acc;
                            fld = FLD_MAXVAL;
                        end else if (acc != MAXVAL_OK) begin
                            abort_file(ST_MAXVAL_NE);
                        end else begin
                            left = PIXCNT_W'(wd * ht * 3);
                            ph   = PH_PIX;
                        end
                        acc = '0;
                    end
                end else if (b == CH_HASH && ndig == 0) begin
                    ph = PH_CMT1;
                end else begin
                    abort_file(bad_field_code());
                end
            end
            PH_PIX: begin
                if (left != 0) begin
                    r.pixel_valid = 1'b1;
                    r.pixel_byte  = b;
                    left = left - 1'b1;
                end else begin
                    abort_file(ST_SIZE);
                end
            end
            PH_ERR: ph = PH_ERR;
            default: abort_file(ST_TRUNC);
        endcase

        // The final byte of a file always reports, then the parser starts afresh.
        if (eof) begin
            if (ph == PH_ERR) r.status = err;
            else if (ph == PH_PIX) r.status = (left == 0) ? ST_OK : ST_SIZE;
            else if (ph == PH_FIELD && ndig != 0) r.status = bad_field_code();
            else r.status = ST_TRUNC;
            r.report_valid = 1'b1;
            r.image_width  = wd;
            r.image_height = ht;
            reset_parser();
        end
        if (r.pixel_valid || r.report_valid) predicted_out_q.push_back(r);
    endtask

    // Idling percentages for the current quarter of the run.
    function automatic int idle_pct(input bit for_sink);
        int quarter;
        quarter = (n_acc * 4) / total_words;
        case (quarter)
            0:       return 0;
            1:       return for_sink ? 0 : 49;
            2:       return for_sink ? 49 : 0;
            default: return 29;
        endcase
    endfunction

    // Driver: presents queued words and feeds every accepted word to the model.
    always @(posedge clk) begin : driver_proc
        t_in_word w;
        if (!rst_n) begin
            src_valid <= 1'b0;
        end else begin
            if (src_valid && src_ready) begin
                parse_byte(src_byte, src_last);
                n_acc <= n_acc + 1;
            end
            if (!src_valid || src_ready) begin
                if (file_words_q.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b0)) begin
                    w = file_words_q.pop_front();
                    src_valid <= 1'b1;
                    src_byte  <= w.file_byte;
                    src_last  <= w.end_of_file;
                end else begin
                    src_valid <= 1'b0;
                end
            end
        end
    end

    // One long receiver hold-off early in the run, while the sender keeps offering.
    always @(posedge clk) begin
        if (!rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && n_acc >= total_words / 8) begin
            hold_left <= 400;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    task automatic cmp_field(input string what, input int exp_v, input int got_v);
        if (exp_v != got_v) begin
            n_errors++;
            $display("%0t: %s expected %0d, got %0d", $time, what, exp_v, got_v);
        end
    endtask

    // Monitor: drives the sink's ready and checks each accepted output word.
    always @(posedge clk) begin : monitor_proc
        t_result e;
        if (!rst_n) begin
            sink_ready <= 1'b0;
        end else begin
            if (out_valid && sink_ready) begin
                if (predicted_out_q.size() == 0) begin
                    n_errors++;
                    $display("%0t: unexpected word, expected none, got data %h user %b",
                             $time, out_data, out_user);
                end else begin
                    e = predicted_out_q.pop_front();
                    cmp_field("pixel_valid", e.pixel_valid, out_user[0]);
                    cmp_field("report_valid", e.report_valid, out_user[1]);
                    cmp_field("pixel_byte", e.pixel_byte, out_data[7:0]);
                    cmp_field("status", e.status, out_data[10:8]);
                    cmp_field("image_width", e.image_width, out_data[24:11]);
                    cmp_field("image_height", e.image_height, out_data[38:25]);
                    if (e.pixel_valid) n_pixels++;
                    if (e.report_valid) begin
                        n_reports++;
                        status_hits[e.status]++;
                    end
                end
            end
            sink_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= idle_pct(1'b1));
        end
    end

    // File building helpers
    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) file_buf.push_back(s[i]);
    endtask

    task automatic add_pixels(input int n);
        for (int i = 0; i < n; i++) file_buf.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic add_number(input int v);
        string s;
        int    len;
        s   = $sformatf("%0d", v);
        len = $urandom_range(s.len(), MAX_DIGITS);
        while (s.len() < len) s = {"0", s};
        add_text(s);
    endtask

    task automatic add_ws();
        case ($urandom_range(0, 3))
            0:       file_buf.push_back(CH_SPACE);
            1:       file_buf.push_back(CH_TAB);
            2:       file_buf.push_back(CH_CR);
            default: file_buf.push_back(CH_LF);
        endcase
    endtask

    // Optional run of whitespace and comments between header tokens.
    task automatic add_gap();
        logic [7:0] c;
        int         n;
        n = $urandom_range(0, 2);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 4) == 0) begin
                file_buf.push_back(CH_HASH);
                for (int k = $urandom_range(0, 5); k > 0; k--) begin
                    c = 8'($urandom_range(0, 255));
                    if (is_line_end(c)) c = CH_HASH;
                    file_buf.push_back(c);
                end
                file_buf.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
            end else begin
                add_ws();
            end
        end
    endtask

    // Move the built file into the word queue, flagging its last byte.
    task automatic ship_file();
        t_in_word w;
        for (int i = 0; i < file_buf.size(); i++) begin
            w.file_byte   = file_buf[i];
            w.end_of_file = (i == file_buf.size() - 1);
            file_words_q.push_back(w);
        end
        file_buf.delete();
        n_files++;
    endtask

    // Mostly well-formed files with random layout and content, some of them damaged.
    task automatic gen_random_file();
        int kind, w, h, mv, sel, cut;
        kind = $urandom_range(0, 99);
        if (kind >= 92) begin
            add_pixels($urandom_range(1, 6));
        end else begin
            sel = $urandom_range(0, 99);
            if (sel < 90) begin
                w = $urandom_range(0, 4);
                h = $urandom_range(0, 4);
            end else if (sel < 97) begin
                w = $urandom_range(5, 12);
                h = $urandom_range(1, 3);
            end else if (sel < 99) begin
                w = $urandom_range(1000, 9999);
                h = 0;
            end else begin
                w = 0;
                h = $urandom_range(1000, 9999);
            end
            mv = 255;
            if (kind >= 84) begin
                case ($urandom_range(0, 3))
                    0:       mv = 0;
                    1:       mv = 254;
                    2:       mv = 256;
                    default: mv = 9999;
                endcase
            end
            add_gap();
            add_text("P6");
            add_gap();
            add_number(w);
            add_ws();
            add_gap();
            add_number(h);
            add_ws();
            add_gap();
            add_number(mv);
            add_ws();
            add_pixels(w * h * 3);
            if (kind >= 60 && kind < 68) begin
                cut = $urandom_range(1, file_buf.size());
                while (file_buf.size() > cut) void'(file_buf.pop_back());
            end else if (kind >= 68 && kind < 76) begin
                file_buf[$urandom_range(0, file_buf.size() - 1)] = 8'($urandom_range(0, 255));
            end else if (kind >= 76 && kind < 84) begin
                add_pixels(1);
            end
        end
        ship_file();
    endtask

    // Stimulus, reset and end of run
    initial begin
        reset_parser();
        foreach (status_hits[i]) status_hits[i] = 0;

        // Directed files: every status, extreme sizes, comments and early ends.
        add_text("P6 1 1 255\n");
        file_buf.push_back(8'h00);
        file_buf.push_back(8'hFF);
        file_buf.push_back(8'hA5);
        ship_file();
        add_text("#c");
        file_buf.push_back(CH_CR);
        add_text("P6\t#x\n2");
        file_buf.push_back(CH_CR);
        add_text("1\n0255 ");
        add_pixels(6);
        ship_file();
        add_text("X");            ship_file();
        add_text("PQ");           ship_file();
        add_text("P6 1a 1 255 "); ship_file();
        add_text("P6 1 x");       ship_file();
        add_text("P6 1 1 25#");   ship_file();
        add_text("P6 12345 ");    ship_file();
        add_text("P6 1 1 254 ");  add_pixels(3); ship_file();
        add_text("P6 1 1 255 ");  add_pixels(4); ship_file();
        add_text("P6 1 1 255 ");  add_pixels(2); ship_file();
        add_text("P6 1 12");      ship_file();
        add_text("P6 1 1 255");   ship_file();
        add_text("P");            ship_file();
        add_text("P6 #abc");      ship_file();
        add_text("P6 1 ");        ship_file();
        add_text("P6 9999 0 255\n"); ship_file();
        add_text("P6 0 9999 255 ");  ship_file();

        while (file_words_q.size() < 1850) gen_random_file();
        total_words = file_words_q.size();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every word to be taken, then for the results to drain.
        while (file_words_q.size() != 0 || src_valid) @(posedge clk);
        for (int i = 0; i < 5000 && predicted_out_q.size() != 0; i++) @(posedge clk);
        if (predicted_out_q.size() != 0) begin
            n_errors++;
            $display("%0t: %0d expected words never arrived", $time, predicted_out_q.size());
        end
        repeat (8) @(posedge clk);

        $display("Run covered %0d files in %0d bytes: %0d pixel words and %0d reports checked.",
                 n_files, n_acc, n_pixels, n_reports);
        $display("Reports by status ok..truncated: %0d %0d %0d %0d %0d %0d %0d %0d",
                 status_hits[0], status_hits[1], status_hits[2], status_hits[3],
                 status_hits[4], status_hits[5], status_hits[6], status_hits[7]);
        if (n_errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[ppm_p6_stream_parser_core.f]
rtl/core/ppm_pkg.sv
rtl/core/ppm_in_stage.sv
rtl/core/ppm_hdr_parser.sv
rtl/core/ppm_out_reg.sv
rtl/core/ppm_p6_stream_parser_core.sv
tb/tb.sv
